// ===== rtl/bgl_pkg.sv =====
`default_nettype none
package bgl_pkg;

  // Request modes carried on the mode field.
  typedef enum logic [1:0] {
    MODE_SPEC  = 2'd0,
    MODE_BIN   = 2'd1,
    MODE_COV   = 2'd2,
    MODE_MODEL = 2'd3
  } mode_t;

  localparam int FRAC_BITS = 24;

  // Saturating 64-bit signed addition.
  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/bgl_ram.sv =====
`default_nettype none
module bgl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/bgl_div.sv =====
`default_nettype none
module bgl_div #(
  parameter int VB = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [63:0] num,
  input  wire logic signed [63:0] den,
  output logic                    done,
  output logic signed [VB-1:0]    quot
);
  import bgl_pkg::*;

  localparam int STEPS = 64 + FRAC_BITS;
  localparam logic [87:0] VMAXU = 88'((64'd1 << (VB - 1)) - 64'd1);

  logic        busy;
  logic [6:0]  step;
  logic        neg;
  logic [63:0] dm;
  logic [87:0] nsh;
  logic [64:0] rem;
  logic [87:0] q;
  logic [64:0] trial;
  logic [87:0] lim;

  // Restoring division, one quotient bit per cycle, on the magnitudes.
  assign trial = {rem[63:0], nsh[87]};
  assign lim   = neg ? VMAXU + 88'd1 : VMAXU;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
      neg  <= num[63] ^ den[63];
      dm   <= den[63] ? 64'(-den) : 64'(den);
      nsh  <= {(num[63] ? 64'(-num) : 64'(num)), 24'd0};
      rem  <= '0;
      q    <= '0;
    end else if (busy) begin
      nsh <= nsh << 1;
      if (trial >= {1'b0, dm}) begin
        rem <= trial - {1'b0, dm};
        q   <= {q[86:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[86:0], 1'b0};
      end
      step <= step + 7'd1;
      if (step == 7'(STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Saturate and sign the final quotient in the cycle after the last step.
  logic        fin;
  logic [87:0] qs;
  assign qs = (q > lim) ? lim : q;

  // The done flag rises in the cycle in which the quotient is ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      fin  <= busy && step == 7'(STEPS - 1);
      done <= fin;
    end
    if (fin) begin
      quot <= neg ? VB'(-qs) : VB'(qs);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/binned_gaussian_likelihood_top.sv =====
`default_nettype none
// Channel  | Direction | Handshake        | Payload
// request  | in        | valid / stall    | mode index column value_a value_b range_low ...
// result   | out       | out_valid / out_stall | log_likelihood status
// config   | in        | cfg_we           | cfg_data (bin_count)
// Table and model requests are taken one per cycle while the block is idle; each is a
// memory write. A request in model mode with last set starts the evaluation; requests are
// held off until the result has been taken. For each bin the table entry is read, then
// each multipole is read, passes the two multiply stages and is added; the 88-step divider
// then forms the estimate (skipped when its denominator is zero). The quadratic form then
// runs over all n*n elements, and the result is registered after it. Reset is synchronous,
// active high; the memories have no reset.
module binned_gaussian_likelihood_top #(
  parameter int MAX_MULTIPOLES = 2048,
  parameter int MAX_BINS       = 64,
  parameter int VALUE_BITS     = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_data,
  input  wire logic        valid,
  output logic             stall,
  input  wire logic [1:0]  mode,
  input  wire logic [10:0] index,
  input  wire logic [5:0]  column,
  input  wire logic [31:0] value_a,
  input  wire logic [31:0] value_b,
  input  wire logic [10:0] range_low,
  input  wire logic [10:0] range_high,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      log_likelihood,
  output logic             status
);
  import bgl_pkg::*;

  localparam int VB = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int LA = $clog2(MAX_MULTIPOLES);
  localparam int BA = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int BD = 1 << BA;
  localparam logic signed [63:0] VMAX = (64'sd1 <<< (VB - 1)) - 64'sd1;
  localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;

  typedef enum logic [3:0] {
    S_IDLE, S_BIN_RD, S_BIN_WT, S_L_RD, S_L_ACC, S_L_MUL2, S_L_ADD, S_DIV, S_DIV_WT,
    S_Q_RD, S_Q_WT, S_Q_MUL, S_Q_MUL2, S_Q_ADD, S_OUT
  } state_t;

  state_t state;

  // Bin count register.
  logic [6:0] bin_count;
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count <= 7'd1;
    end else if (cfg_we) begin
      bin_count <= cfg_data;
    end
  end

  logic [8:0] nbins;
  assign nbins = ({2'd0, bin_count} > 9'(MAX_BINS)) ? 9'(MAX_BINS) : {2'd0, bin_count};

  // Request decode.
  logic acc;
  assign stall = (state != S_IDLE);
  assign acc   = valid && !stall;

  logic idx_l_ok, idx_b_ok, col_ok;
  assign idx_l_ok = {21'd0, index} < 32'(MAX_MULTIPOLES);
  assign idx_b_ok = {21'd0, index} < 32'(MAX_BINS);
  assign col_ok   = {26'd0, column} < 32'(MAX_BINS);

  logic signed [VB-1:0] va, vb;
  assign va = value_a[VB-1:0];
  assign vb = value_b[VB-1:0];

  // Addresses driven by the sequencer.
  logic [LA-1:0] l_addr;
  logic [BA-1:0] bi, bj;
  logic [12:0]   lcur;

  // Spectrum memories.
  logic [LA-1:0] sp_waddr;
  assign sp_waddr = LA'(index);
  logic [VB-1:0] fid_q, ivar_q, mod_q;
  bgl_ram #(.WIDTH(VB), .DEPTH(MAX_MULTIPOLES)) u_fid (
    .clk(clk), .wr_en(acc && mode == MODE_SPEC && idx_l_ok), .wr_addr(sp_waddr),
    .wr_data(va), .rd_addr(l_addr), .rd_data(fid_q));
  bgl_ram #(.WIDTH(VB), .DEPTH(MAX_MULTIPOLES)) u_ivar (
    .clk(clk), .wr_en(acc && mode == MODE_SPEC && idx_l_ok), .wr_addr(sp_waddr),
    .wr_data(vb), .rd_addr(l_addr), .rd_data(ivar_q));
  bgl_ram #(.WIDTH(VB), .DEPTH(MAX_MULTIPOLES)) u_model (
    .clk(clk), .wr_en(acc && mode == MODE_MODEL && idx_l_ok), .wr_addr(sp_waddr),
    .wr_data(va), .rd_addr(l_addr), .rd_data(mod_q));

  // Bin table: start, end and measured value in one word.
  localparam int BW = 22 + VB;
  logic [BW-1:0] bin_q;
  bgl_ram #(.WIDTH(BW), .DEPTH(BD)) u_bin (
    .clk(clk), .wr_en(acc && mode == MODE_BIN && idx_b_ok), .wr_addr(BA'(index)),
    .wr_data({range_low, range_high, va}), .rd_addr(bi), .rd_data(bin_q));

  // Inverse covariance at row * BD + column.
  logic [VB-1:0] cov_q;
  bgl_ram #(.WIDTH(VB), .DEPTH(BD * BD)) u_cov (
    .clk(clk), .wr_en(acc && mode == MODE_COV && idx_b_ok && col_ok),
    .wr_addr({BA'(index), BA'(column)}), .wr_data(va),
    .rd_addr({bi, bj}), .rd_data(cov_q));

  // Residual memory, read at two addresses, so two copies.
  logic          res_we;
  logic [VB-1:0] res_d, ri_q, rj_q;
  bgl_ram #(.WIDTH(VB), .DEPTH(BD)) u_res_i (
    .clk(clk), .wr_en(res_we), .wr_addr(bi), .wr_data(res_d), .rd_addr(bi), .rd_data(ri_q));
  bgl_ram #(.WIDTH(VB), .DEPTH(BD)) u_res_j (
    .clk(clk), .wr_en(res_we), .wr_addr(bi), .wr_data(res_d), .rd_addr(bj), .rd_data(rj_q));

  // Divider.
  logic                 div_start, div_done;
  logic signed [VB-1:0] div_q;
  logic signed [63:0]   num, den;
  bgl_div #(.VB(VB)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(num), .den(den),
    .done(div_done), .quot(div_q));

  // The division starts as the sums are complete, unless the denominator is zero.
  assign div_start = (state == S_DIV) && (den != 64'sd0);

  // Datapath registers.
  logic [10:0]          hi;
  logic signed [VB-1:0] meas, w_r, rr_a, rr_b;
  logic signed [63:0]   p_num, p_den, t_num, t_den, sum, rr;
  logic signed [VB-1:0] c_r;
  logic signed [95:0]   term_p;
  logic                 zero_den;
  logic [8:0]           ci, cj;

  function automatic logic signed [VB-1:0] satv(input logic signed [63:0] x);
    if (x > VMAX) return VB'(VMAX);
    if (x < VMIN) return VB'(VMIN);
    return x[VB-1:0];
  endfunction

  logic signed [63:0] diff;
  assign diff = 64'(div_q) - 64'(meas);

  assign l_addr = lcur[LA-1:0];
  assign bi = ci[BA-1:0];
  assign bj = cj[BA-1:0];

  logic signed [63:0] resq;
  assign resq = zero_den ? 64'(0) - 64'(meas) : diff;

  // The residual is written at the current bin as its estimate becomes ready.
  assign res_we = (state == S_DIV_WT) && (zero_den || div_done);
  assign res_d  = satv(resq);

  // Sequencer: one clocked block holds state and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc && mode == MODE_MODEL && last) begin
            ci     <= '0;
            status <= 1'b0;
            sum    <= '0;
            state  <= (nbins == 9'd0) ? S_OUT : S_BIN_RD;
          end
        end
        S_BIN_RD: state <= S_BIN_WT;
        S_BIN_WT: begin
          lcur  <= {2'd0, bin_q[BW-1 -: 11]};
          hi    <= ({21'd0, bin_q[BW-12 -: 11]} > 32'(MAX_MULTIPOLES - 1)) ?
                   11'(MAX_MULTIPOLES - 1) : bin_q[BW-12 -: 11];
          meas  <= bin_q[VB-1:0];
          num   <= '0;
          den   <= '0;
          state <= (bin_q[BW-1 -: 11] > bin_q[BW-12 -: 11] ||
                    {21'd0, bin_q[BW-1 -: 11]} > 32'(MAX_MULTIPOLES - 1)) ? S_DIV : S_L_RD;
        end
        // Read one multipole.
        S_L_RD: state <= S_L_ACC;
        S_L_ACC: begin
          p_num <= (64'(signed'(mod_q)) * 64'(signed'(fid_q))) >>> FRAC_BITS;
          p_den <= (64'(signed'(fid_q)) * 64'(signed'(fid_q))) >>> FRAC_BITS;
          w_r   <= ivar_q;
          state <= S_L_MUL2;
        end
        S_L_MUL2: begin
          t_num <= (64'(satv(p_num)) * 64'(w_r)) >>> FRAC_BITS;
          t_den <= (64'(satv(p_den)) * 64'(w_r)) >>> FRAC_BITS;
          state <= S_L_ADD;
        end
        S_L_ADD: begin
          num <= sat_add64(num, t_num);
          den <= sat_add64(den, t_den);
          if (lcur[10:0] == hi) begin
            state <= S_DIV;
          end else begin
            lcur  <= lcur + 13'd1;
            state <= S_L_RD;
          end
        end
        S_DIV: begin
          zero_den <= (den == 64'sd0);
          if (den == 64'sd0) begin
            status <= 1'b1;
          end
          state <= S_DIV_WT;
        end
        S_DIV_WT: begin
          if (zero_den || div_done) begin
            if (ci == nbins - 9'd1) begin
              ci    <= '0;
              cj    <= '0;
              state <= S_Q_RD;
            end else begin
              ci    <= ci + 9'd1;
              state <= S_BIN_RD;
            end
          end
        end
        // Quadratic form, row-major.
        S_Q_RD: state <= S_Q_WT;
        S_Q_WT: begin
          rr_a  <= ri_q;
          rr_b  <= rj_q;
          c_r   <= cov_q;
          state <= S_Q_MUL;
        end
        S_Q_MUL: begin
          rr    <= (64'(rr_a) * 64'(rr_b)) >>> FRAC_BITS;
          state <= S_Q_MUL2;
        end
        S_Q_MUL2: begin
          term_p <= (96'(rr) * 96'(c_r)) >>> 16;
          state  <= S_Q_ADD;
        end
        S_Q_ADD: begin
          sum <= sat_add64(sum, term_p[63:0]);
          if (cj == nbins - 9'd1) begin
            cj <= '0;
            if (ci == nbins - 9'd1) begin
              state <= S_OUT;
            end else begin
              ci    <= ci + 9'd1;
              state <= S_Q_RD;
            end
          end else begin
            cj    <= cj + 9'd1;
            state <= S_Q_RD;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid      <= 1'b1;
            log_likelihood <= 64'(-(sum >>> 1));
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bgl_checker.sv =====
`default_nettype none
module bgl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] log_likelihood,
  input wire logic        status
);

  // A waiting result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(log_likelihood) && $stable(status))
    else $error("result changed while stalled");

  // No request is taken while a result is shown.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> stall)
    else $error("request taken during result");

  // After a result is taken, out_valid falls and the result is not repeated.
  a_free: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid)
    else $error("result repeated");

endmodule

bind binned_gaussian_likelihood_top bgl_checker u_chk (
  .clk(clk), .rst(rst), .stall(stall), .out_valid(out_valid),
  .out_stall(out_stall), .log_likelihood(log_likelihood), .status(status));
`default_nettype wire
